// File: rtl/c3rgb_pkg.sv
package c3rgb_pkg;

   localparam int MAX_WIDTH_DEF = 2048;

   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int TAPS    = 9;
   localparam int LANES   = 3;
   localparam int ACC_W   = 20;
   localparam int DIV_W   = 16;
   localparam int DMAG_W  = 17;
   localparam int BIAS_W  = 9;
   localparam int CIDX_W  = 3;
   localparam int CDATA_W = 24;

   localparam logic [7:0] CLAMP_MAX = 8'd255;

   localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
   localparam logic [CIDX_W-1:0] REG_COEF_TOP    = 3'd1;
   localparam logic [CIDX_W-1:0] REG_COEF_MIDDLE = 3'd2;
   localparam logic [CIDX_W-1:0] REG_COEF_BOTTOM = 3'd3;
   localparam logic [CIDX_W-1:0] REG_DIVISOR     = 3'd4;
   localparam logic [CIDX_W-1:0] REG_BIAS        = 3'd5;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_LOAD,
      TOP_RUN
   } top_state_type;

   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_MAC,
      LANE_DIV,
      LANE_FIN
   } lane_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } lane_ctrl_type;

endpackage

// File: rtl/c3rgb_ram.sv
module c3rgb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/c3rgb_lane.sv
module c3rgb_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  c3rgb_pkg::lane_ctrl_type            ctrl,
   input  logic [c3rgb_pkg::TAPS-1:0][7:0]     pixels,
   input  logic [c3rgb_pkg::TAPS-1:0][7:0]     coefs,
   input  logic [c3rgb_pkg::DIV_W-1:0]         divisor,
   input  logic [c3rgb_pkg::BIAS_W-1:0]        bias,
   output logic                                done,
   output logic [7:0]                          result
);

   localparam int AW = c3rgb_pkg::ACC_W;
   localparam int DW = c3rgb_pkg::DMAG_W;

   c3rgb_pkg::lane_state_type state_ff, state_in;

   logic [c3rgb_pkg::TAPS-1:0][7:0] pix_ff, coef_ff;
   logic [7:0]                      centre_ff;
   logic                            bypass_ff, bypass_in;
   logic [DW-1:0]                   dmag_ff, dmag_in;
   logic                            dneg_ff, dneg_in;
   logic [c3rgb_pkg::BIAS_W-1:0]    bias_ff;
   logic signed [AW-1:0]            acc_ff, acc_in;
   logic [3:0]                      tap_ff, tap_in;
   logic [4:0]                      step_ff, step_in;
   logic [AW-1:0]                   dvd_ff, dvd_in;
   logic [AW-1:0]                   quo_ff, quo_in;
   logic [DW:0]                     rem_ff, rem_in;
   logic                            qneg_ff, qneg_in;

   logic signed [16:0]   prod;
   logic [DW:0]          trial;
   logic signed [AW:0]   qsigned;
   logic signed [AW:0]   value;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         c3rgb_pkg::LANE_IDLE: begin
            if (ctrl.start) begin
               state_in = (divisor == '0) ? c3rgb_pkg::LANE_FIN : c3rgb_pkg::LANE_MAC;
            end
         end
         c3rgb_pkg::LANE_MAC: begin
            if (tap_ff == 4'(c3rgb_pkg::TAPS - 1)) state_in = c3rgb_pkg::LANE_DIV;
         end
         c3rgb_pkg::LANE_DIV: begin
            if (step_ff == 5'(AW)) state_in = c3rgb_pkg::LANE_FIN;
         end
         c3rgb_pkg::LANE_FIN: begin
            if (ctrl.ack) state_in = c3rgb_pkg::LANE_IDLE;
         end
         default: state_in = c3rgb_pkg::LANE_IDLE;
      endcase
   end

   assign prod  = $signed(coef_ff[tap_ff]) * $signed({1'b0, pix_ff[tap_ff]});
   assign trial = {rem_ff[DW-1:0], dvd_ff[AW-1]};

   always_comb begin
      bypass_in = bypass_ff;
      dmag_in   = dmag_ff;
      dneg_in   = dneg_ff;
      acc_in    = acc_ff;
      tap_in    = tap_ff;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      qneg_in   = qneg_ff;
      case (state_ff)
         c3rgb_pkg::LANE_IDLE: begin
            bypass_in = (divisor == '0);
            dneg_in   = divisor[c3rgb_pkg::DIV_W-1];
            dmag_in   = divisor[c3rgb_pkg::DIV_W-1] ?
                        (DW'(0) - {1'b1, divisor}) : {1'b0, divisor};
            acc_in    = '0;
            tap_in    = '0;
         end
         c3rgb_pkg::LANE_MAC: begin
            acc_in = acc_ff + AW'(prod);
            tap_in = tap_ff + 4'd1;
            if (tap_ff == 4'(c3rgb_pkg::TAPS - 1)) begin
               qneg_in = acc_in[AW-1] ^ dneg_ff;
               dvd_in  = acc_in[AW-1] ? (AW'(0) - AW'(acc_in)) : AW'(acc_in);
               rem_in  = '0;
               quo_in  = '0;
               step_in = '0;
            end
         end
         c3rgb_pkg::LANE_DIV: begin
            if (step_ff != 5'(AW)) begin
               // one quotient bit per cycle, restoring
               if (trial >= {1'b0, dmag_ff}) begin
                  rem_in = trial - {1'b0, dmag_ff};
                  quo_in = {quo_ff[AW-2:0], 1'b1};
               end else begin
                  rem_in = trial;
                  quo_in = {quo_ff[AW-2:0], 1'b0};
               end
               dvd_in  = {dvd_ff[AW-2:0], 1'b0};
               step_in = step_ff + 5'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c3rgb_pkg::LANE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == c3rgb_pkg::LANE_IDLE && ctrl.start) begin
         pix_ff    <= pixels;
         coef_ff   <= coefs;
         centre_ff <= pixels[4];
         bias_ff   <= bias;
      end
      bypass_ff <= bypass_in;
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      acc_ff    <= acc_in;
      tap_ff    <= tap_in;
      step_ff   <= step_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      qneg_ff   <= qneg_in;
   end

   // sign the quotient, add bias, clamp to a byte; a zero divisor passes the centre through
   assign qsigned = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign value   = qsigned + (AW+1)'($signed(bias_ff));

   always_comb begin
      if (bypass_ff) begin
         result = centre_ff;
      end else if (value < 0) begin
         result = '0;
      end else if (value > $signed((AW+1)'(c3rgb_pkg::CLAMP_MAX))) begin
         result = c3rgb_pkg::CLAMP_MAX;
      end else begin
         result = value[7:0];
      end
   end

   assign done = (state_ff == c3rgb_pkg::LANE_FIN);

endmodule

// File: rtl/conv3x3_rgb_filter_core.sv
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall blue_in, green_in, red_in, frame_end
// rsp      out        rsp_valid/rsp_stall blue_out, green_out, red_out, row_done, frame_done
// csr      in         csr_valid/csr_ready csr_index, csr_data
//
// One pixel at a time: a border pixel only passes the load state, while an
// interior pixel also waits on the 9-tap multiply-accumulate and the 20-step
// bit-serial divider in each channel lane; a zero divisor skips both.
// Reset is synchronous and clears control, configuration and window
// registers; line stores start undefined. A result waits in the output
// register while the next pixel is taken; the lanes hold their result while rsp stalls.
module conv3x3_rgb_filter_core #(
   parameter int MAX_WIDTH = c3rgb_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_blue_in,
   input  logic [7:0]                        req_green_in,
   input  logic [7:0]                        req_red_in,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_blue_out,
   output logic [7:0]                        rsp_green_out,
   output logic [7:0]                        rsp_red_out,
   output logic                              rsp_row_done,
   output logic                              rsp_frame_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [c3rgb_pkg::CIDX_W-1:0]      csr_index,
   input  logic [c3rgb_pkg::CDATA_W-1:0]     csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WB = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
   localparam int PW = c3rgb_pkg::PIX_W;

   // configuration
   logic [11:0]                      image_width_ff;
   logic [PW-1:0]                    coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [c3rgb_pkg::DIV_W-1:0]      divisor_ff;
   logic [c3rgb_pkg::BIAS_W-1:0]     bias_ff;

   c3rgb_pkg::top_state_type state_ff, state_in;

   logic [AW-1:0]   column_ff;
   logic [1:0]      rows_ff;
   logic [PW-1:0]   win_ff [6];
   logic [PW-1:0]   bot_ff;
   logic [AW-1:0]   col_ff;
   logic            last_ff, fend_ff, emit_ff;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_blue_ff, rsp_green_ff, rsp_red_ff;
   logic            rsp_row_ff, rsp_frame_ff;
   logic            row_tag_ff, frame_tag_ff;

   logic [WB-1:0]   width_eff;
   logic [AW-1:0]   col_now;
   logic            req_take, out_free;
   logic [PW-1:0]   rd_upper, rd_lower;
   logic [PW-1:0]   pix [c3rgb_pkg::TAPS];
   logic [c3rgb_pkg::TAPS-1:0][7:0] coefs;
   logic [c3rgb_pkg::LANES-1:0][c3rgb_pkg::TAPS-1:0][7:0] lane_pix;
   logic [c3rgb_pkg::LANES-1:0]      lane_done;
   logic [c3rgb_pkg::LANES-1:0][7:0] lane_res;
   c3rgb_pkg::lane_ctrl_type         lane_ctrl;
   logic            ram_we, load_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= 12'd640;
         coef_top_ff    <= '0;
         coef_mid_ff    <= 24'd256;
         coef_bot_ff    <= '0;
         divisor_ff     <= 16'd1;
         bias_ff        <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            c3rgb_pkg::REG_IMAGE_WIDTH: image_width_ff <= csr_data[11:0];
            c3rgb_pkg::REG_COEF_TOP:    coef_top_ff    <= csr_data;
            c3rgb_pkg::REG_COEF_MIDDLE: coef_mid_ff    <= csr_data;
            c3rgb_pkg::REG_COEF_BOTTOM: coef_bot_ff    <= csr_data;
            c3rgb_pkg::REG_DIVISOR:     divisor_ff     <= csr_data[15:0];
            c3rgb_pkg::REG_BIAS:        bias_ff        <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // clamp width to 3..MAX_WIDTH, clamp column below it
   always_comb begin
      width_eff = WB'(image_width_ff);
      if (width_eff < WB'(3)) width_eff = WB'(3);
      if (width_eff > WB'(MAX_WIDTH)) width_eff = WB'(MAX_WIDTH);
      col_now = (WB'(column_ff) >= width_eff) ? AW'(width_eff - WB'(1)) : column_ff;
   end

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         c3rgb_pkg::TOP_IDLE: if (req_take) state_in = c3rgb_pkg::TOP_LOAD;
         c3rgb_pkg::TOP_LOAD: state_in = emit_ff ? c3rgb_pkg::TOP_RUN : c3rgb_pkg::TOP_IDLE;
         c3rgb_pkg::TOP_RUN:  if ((&lane_done) && out_free) state_in = c3rgb_pkg::TOP_IDLE;
         default:             state_in = c3rgb_pkg::TOP_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall       = 1'b1;
      ram_we          = 1'b0;
      lane_ctrl.start = 1'b0;
      lane_ctrl.ack   = 1'b0;
      load_out        = 1'b0;
      case (state_ff)
         c3rgb_pkg::TOP_IDLE: req_stall = 1'b0;
         c3rgb_pkg::TOP_LOAD: begin
            ram_we          = 1'b1;
            lane_ctrl.start = emit_ff;
         end
         c3rgb_pkg::TOP_RUN: begin
            load_out      = (&lane_done) && out_free;
            lane_ctrl.ack = load_out;
         end
         default: ;
      endcase
   end

   c3rgb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata (rd_lower),
      .raddr (col_now),
      .rdata (rd_upper)
   );

   c3rgb_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_lower (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata (bot_ff),
      .raddr (col_now),
      .rdata (rd_lower)
   );

   // 3x3 window, rows top..bottom, columns left..right
   always_comb begin
      pix[0] = win_ff[0]; pix[1] = win_ff[3]; pix[2] = rd_upper;
      pix[3] = win_ff[1]; pix[4] = win_ff[4]; pix[5] = rd_lower;
      pix[6] = win_ff[2]; pix[7] = win_ff[5]; pix[8] = bot_ff;
      coefs  = {coef_bot_ff[23:16], coef_bot_ff[15:8], coef_bot_ff[7:0],
                coef_mid_ff[23:16], coef_mid_ff[15:8], coef_mid_ff[7:0],
                coef_top_ff[23:16], coef_top_ff[15:8], coef_top_ff[7:0]};
      for (int l = 0; l < c3rgb_pkg::LANES; l++) begin
         for (int t = 0; t < c3rgb_pkg::TAPS; t++) begin
            lane_pix[l][t] = pix[t][8*l +: 8];
         end
      end
   end

   // one lane per channel: blue, green, red
   for (genvar l = 0; l < c3rgb_pkg::LANES; l++) begin : g_lane
      c3rgb_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .pixels  (lane_pix[l]),
         .coefs   (coefs),
         .divisor (divisor_ff),
         .bias    (bias_ff),
         .done    (lane_done[l]),
         .result  (lane_res[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= c3rgb_pkg::TOP_IDLE;
         column_ff    <= '0;
         rows_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == c3rgb_pkg::TOP_LOAD) begin
            // advance the window and the raster position
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= rd_upper;
            win_ff[4] <= rd_lower;
            win_ff[5] <= bot_ff;
            if (fend_ff) begin
               column_ff <= '0;
               rows_ff   <= '0;
            end else if (last_ff) begin
               column_ff <= '0;
               if (rows_ff != 2'd2) rows_ff <= rows_ff + 2'd1;
            end else begin
               column_ff <= col_ff + AW'(1);
            end
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         bot_ff  <= {req_red_in, req_green_in, req_blue_in};
         col_ff  <= col_now;
         last_ff <= (WB'(col_now) == width_eff - WB'(1));
         fend_ff <= req_frame_end;
         emit_ff <= (rows_ff == 2'd2) && (col_now >= AW'(2));
      end
      if (lane_ctrl.start) begin
         row_tag_ff   <= last_ff;
         frame_tag_ff <= fend_ff;
      end
      if (load_out) begin
         rsp_blue_ff  <= lane_res[0];
         rsp_green_ff <= lane_res[1];
         rsp_red_ff   <= lane_res[2];
         rsp_row_ff   <= row_tag_ff;
         rsp_frame_ff <= frame_tag_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blue_out   = rsp_blue_ff;
   assign rsp_green_out  = rsp_green_ff;
   assign rsp_red_out    = rsp_red_ff;
   assign rsp_row_done   = rsp_row_ff;
   assign rsp_frame_done = rsp_frame_ff;

endmodule

// File: tb/sv/tb_conv3x3_rgb_filter_core.sv
module tb_conv3x3_rgb_filter_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH  = c3rgb_pkg::MAX_WIDTH_DEF;
   localparam int IDX_W       = c3rgb_pkg::CIDX_W;
   localparam int DATA_W      = c3rgb_pkg::CDATA_W;
   // Allow well over the time a pixel spends in the lanes.
   localparam int DRAIN_WAIT  = 80;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       row_done;
      logic       frame_done;
   } filt_pixel_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_blue_in;
   logic [7:0]          req_green_in;
   logic [7:0]          req_red_in;
   logic                req_frame_end;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_blue_out;
   logic [7:0]          rsp_green_out;
   logic [7:0]          rsp_red_out;
   logic                rsp_row_done;
   logic                rsp_frame_done;
   logic                csr_valid;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index;
   logic [DATA_W-1:0]   csr_data;

   conv3x3_rgb_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_blue_in    (req_blue_in),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_row_done   (rsp_row_done),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Mirror of the filter registers as the block should hold them.
   logic [11:0] width_reg;
   logic [23:0] coef_top, coef_mid, coef_bot;
   logic [15:0] divisor_reg;
   logic [8:0]  bias_reg;

   // Mirror of the line stores, the 2x3 window and the raster position.
   logic [23:0] upper_line [LINE_DEPTH];
   logic [23:0] lower_line [LINE_DEPTH];
   logic [23:0] win [6];
   int unsigned col_pos;
   int unsigned rows_cnt;

   filt_pixel_type filtered_q[$];

   int errors;
   int unsigned cycles;
   int send_idle_pct;
   int recv_idle_pct;
   int unsigned pixels_sent;

   // 8 ns clock.
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Signed byte pos of a packed weight row.
   function automatic int weight(input logic [23:0] row, input int pos);
      return int'($signed(row[8*pos +: 8]));
   endfunction

   // One channel of the centre pixel: weighted sum, divide toward zero,
   // add bias, clamp. Zero divisor hands the centre through untouched.
   function automatic logic [7:0] filter_chan(input logic [8:0][23:0] px, input int ch);
      logic [23:0] rows [3];
      int sum, d, v;
      rows[0] = coef_top;
      rows[1] = coef_mid;
      rows[2] = coef_bot;
      d = int'($signed(divisor_reg));
      if (d == 0) return px[4][8*ch +: 8];
      sum = 0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            sum += weight(rows[r], c) * int'(px[r*3+c][8*ch +: 8]);
      v = sum / d + int'($signed(bias_reg));
      if (v < 0) v = 0;
      if (v > int'(c3rgb_pkg::CLAMP_MAX)) v = int'(c3rgb_pkg::CLAMP_MAX);
      return v[7:0];
   endfunction

   // Advance the mirror by one accepted pixel; queue the filtered centre
   // when the window holds a full interior neighborhood.
   task automatic advance_filter(input logic [23:0] pix, input logic fend);
      int unsigned w, c;
      logic [23:0] top, mid;
      logic [8:0][23:0] px;
      filt_pixel_type res;
      logic last_col;
      w = 32'(width_reg);
      if (w < 3) w = 3;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      c = col_pos;
      if (c >= w) c = w - 1;
      last_col = (c == w - 1);
      top = upper_line[c];
      mid = lower_line[c];
      if (rows_cnt >= 2 && c >= 2) begin
         px[0] = win[0]; px[1] = win[3]; px[2] = top;
         px[3] = win[1]; px[4] = win[4]; px[5] = mid;
         px[6] = win[2]; px[7] = win[5]; px[8] = pix;
         res.blue       = filter_chan(px, 0);
         res.green      = filter_chan(px, 1);
         res.red        = filter_chan(px, 2);
         res.row_done   = last_col;
         res.frame_done = fend;
         filtered_q.push_back(res);
      end
      win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
      win[3] = top;    win[4] = mid;    win[5] = pix;
      upper_line[c] = mid;
      lower_line[c] = pix;
      if (fend) begin
         col_pos  = 0;
         rows_cnt = 0;
      end else if (last_col) begin
         col_pos = 0;
         if (rows_cnt < 2) rows_cnt++;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // Send one pixel beat; hold it until the block takes it.
   task automatic send_pixel(input logic [23:0] pix, input logic fend);
      req_valid     <= 1'b1;
      req_blue_in   <= pix[7:0];
      req_green_in  <= pix[15:8];
      req_red_in    <= pix[23:16];
      req_frame_end <= fend;
      do @(posedge clock); while (req_stall);
      advance_filter(pix, fend);
      pixels_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drain: drop valid, every expected beat back, then let a border pixel finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         c3rgb_pkg::REG_IMAGE_WIDTH: width_reg   = val[11:0];
         c3rgb_pkg::REG_COEF_TOP:    coef_top    = val;
         c3rgb_pkg::REG_COEF_MIDDLE: coef_mid    = val;
         c3rgb_pkg::REG_COEF_BOTTOM: coef_bot    = val;
         c3rgb_pkg::REG_DIVISOR:     divisor_reg = val[15:0];
         c3rgb_pkg::REG_BIAS:        bias_reg    = val[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return 32'(width_reg);
   endfunction

   function automatic logic [23:0] rand_pixel();
      return 24'($urandom);
   endfunction

   // Send a whole frame of rows x current width, frame_end on the last pixel.
   // A broken frame is cut short at a random pixel.
   task automatic send_frame(input int unsigned rows, input bit broken);
      int unsigned n, total;
      total = rows * eff_width();
      n = broken ? $urandom_range(1, total) : total;
      for (int unsigned i = 1; i <= n; i++)
         send_pixel(rand_pixel(), i == n);
   endtask

   // Pick a fresh filter setting; weighted toward small widths and small
   // divisors so that results stay inside the clamp often enough.
   task automatic random_setup();
      logic [23:0] wv, dv, bv;
      case ($urandom_range(9))
         0:       wv = 24'($urandom_range(0, 2));
         1:       wv = 24'($urandom_range(11, 24));
         default: wv = 24'($urandom_range(3, 10));
      endcase
      case ($urandom_range(9))
         0:       dv = 24'h0000;
         1:       dv = 24'h8000;
         2:       dv = 24'h7fff;
         3:       dv = 24'($urandom);
         4:       dv = 24'(16'(-$urandom_range(1, 64)));
         default: dv = 24'($urandom_range(1, 200));
      endcase
      bv = 24'($urandom);
      write_reg(c3rgb_pkg::REG_IMAGE_WIDTH, wv);
      write_reg(c3rgb_pkg::REG_COEF_TOP,    24'($urandom));
      write_reg(c3rgb_pkg::REG_COEF_MIDDLE, 24'($urandom));
      write_reg(c3rgb_pkg::REG_COEF_BOTTOM, 24'($urandom));
      write_reg(c3rgb_pkg::REG_DIVISOR,     dv);
      write_reg(c3rgb_pkg::REG_BIAS,        bv);
      // Drop a write at an unused index now and then; nothing must change.
      if ($urandom_range(7) == 0)
         write_reg(IDX_W'($urandom_range(6, 7)), 24'($urandom));
   endtask

   // Width register of zero acts as three; reset weights pass the centre
   // through; the pixels hit both channel extremes.
   task automatic test_min_width_passthrough();
      write_reg(c3rgb_pkg::REG_IMAGE_WIDTH, 24'd0);
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2) ? 24'hffffff : 24'h000000, i == 8);
      wait_idle();
   endtask

   // Frame end on the first row raises no frame_done and restarts the raster.
   task automatic test_frame_end_off_grid();
      send_pixel(24'h123456, 1'b0);
      send_pixel(24'hfedcba, 1'b1);
      wait_idle();
   endtask

   // Extreme weights, most negative divisor, both bias ends, zero divisor.
   task automatic test_extreme_setup();
      write_reg(c3rgb_pkg::REG_COEF_TOP,    24'h7f807f);
      write_reg(c3rgb_pkg::REG_COEF_MIDDLE, 24'h80ff80);
      write_reg(c3rgb_pkg::REG_COEF_BOTTOM, 24'h7f7f7f);
      write_reg(c3rgb_pkg::REG_DIVISOR,     24'h008000);
      write_reg(c3rgb_pkg::REG_BIAS,        24'h0000ff);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 24'h000000 : 24'hffffff, i == 8);
      wait_idle();
      write_reg(c3rgb_pkg::REG_DIVISOR, 24'h000001);
      write_reg(c3rgb_pkg::REG_BIAS,    24'h000100);
      for (int i = 0; i < 9; i++) send_pixel(24'h80ff01, i == 8);
      wait_idle();
      write_reg(c3rgb_pkg::REG_DIVISOR, 24'h000000);
      send_frame(3, 1'b0);
      wait_idle();
   endtask

   // Width register past the store depth: a frame cut short in its first row.
   task automatic test_max_width();
      write_reg(c3rgb_pkg::REG_IMAGE_WIDTH, 24'hfff);
      write_reg(c3rgb_pkg::REG_DIVISOR,     24'h000003);
      for (int i = 0; i < 64; i++) send_pixel(rand_pixel(), i == 63);
      wait_idle();
   endtask

   // Mostly whole frames with random content, some cut short by frame_end.
   task automatic test_random_frames(input int unsigned quota);
      int unsigned start;
      start = pixels_sent;
      while (pixels_sent - start < quota) begin
         random_setup();
         send_frame($urandom_range(3, 6), $urandom_range(5) == 0);
         wait_idle();
      end
   endtask

   // Compare each filtered beat with the oldest expectation.
   always @(posedge clock) begin
      filt_pixel_type exp_pix;
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               $display("%0t: unexpected beat b=%0d g=%0d r=%0d", $time,
                  rsp_blue_out, rsp_green_out, rsp_red_out);
               errors++;
            end else begin
               exp_pix = filtered_q.pop_front();
               if (rsp_blue_out !== exp_pix.blue) begin
                  $display("%0t: blue exp %0d got %0d", $time, exp_pix.blue, rsp_blue_out);
                  errors++;
               end
               if (rsp_green_out !== exp_pix.green) begin
                  $display("%0t: green exp %0d got %0d", $time, exp_pix.green, rsp_green_out);
                  errors++;
               end
               if (rsp_red_out !== exp_pix.red) begin
                  $display("%0t: red exp %0d got %0d", $time, exp_pix.red, rsp_red_out);
                  errors++;
               end
               if (rsp_row_done !== exp_pix.row_done) begin
                  $display("%0t: row_done exp %0b got %0b", $time,
                     exp_pix.row_done, rsp_row_done);
                  errors++;
               end
               if (rsp_frame_done !== exp_pix.frame_done) begin
                  $display("%0t: frame_done exp %0b got %0b", $time,
                     exp_pix.frame_done, rsp_frame_done);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_blue_in   = '0;
      req_green_in  = '0;
      req_red_in    = '0;
      req_frame_end = 1'b0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      errors        = 0;
      cycles        = 0;
      pixels_sent   = 0;
      width_reg     = 12'd640;
      coef_top      = 24'd0;
      coef_mid      = 24'd256;
      coef_bot      = 24'd0;
      divisor_reg   = 16'd1;
      bias_reg      = 9'd0;
      col_pos       = 0;
      rows_cnt      = 0;
      for (int i = 0; i < 6; i++) win[i] = '0;
      send_idle_pct = 37;
      recv_idle_pct = 64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_min_width_passthrough();
      test_frame_end_off_grid();
      test_extreme_setup();

      test_random_frames(500);
      send_idle_pct = 64;
      recv_idle_pct = 37;
      test_random_frames(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(500);
      test_max_width();

      wait_idle();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

// File: conv3x3_rgb_filter_core.f
rtl/c3rgb_pkg.sv
rtl/c3rgb_ram.sv
rtl/c3rgb_lane.sv
rtl/conv3x3_rgb_filter_core.sv
tb/sv/tb_conv3x3_rgb_filter_core.sv
